// ----- rtl/core/bdm_pkg.sv -----
// shared types and constants for the button debouncer with multi-click detection
package bdm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned AGE_W      = 17;
    localparam int unsigned CNT_W      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 3'd0,
        CFG_CLICK_TIMEOUT  = 3'd1,
        CFG_ACTIVE_LOW     = 3'd2,
        CFG_PRESS_TARGET   = 3'd3,
        CFG_RELEASE_TARGET = 3'd4
    } t_cfg_idx;

    localparam logic [15:0]      DEBOUNCE_RST       = 16'd50;
    localparam logic [15:0]      TIMEOUT_RST        = 16'd300;
    localparam logic             ACTIVE_LOW_RST     = 1'b1;
    localparam logic [CNT_W-1:0] PRESS_TARGET_RST   = 8'd2;
    localparam logic [CNT_W-1:0] RELEASE_TARGET_RST = 8'd2;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic             pressed;
        logic             released;
        logic             held;
        logic             changed;
        logic             press_toggle;
        logic             release_toggle;
        logic [CNT_W-1:0] press_count_out;
        logic [CNT_W-1:0] release_count_out;
        logic             multi_press;
        logic             multi_release;
    } t_result;

endpackage

// ----- rtl/core/bdm_if.sv -----
// handshake channels: pin tick input, result output and register writes
interface bdm_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdm_out_if;
    import bdm_pkg::*;
    logic             valid;
    logic             ready;
    logic             pressed;
    logic             released;
    logic             held;
    logic             changed;
    logic             press_toggle;
    logic             release_toggle;
    logic [CNT_W-1:0] press_count_out;
    logic [CNT_W-1:0] release_count_out;
    logic             multi_press;
    logic             multi_release;

    modport source (
        output valid, input ready,
        output pressed, output released, output held, output changed,
        output press_toggle, output release_toggle,
        output press_count_out, output release_count_out,
        output multi_press, output multi_release
    );
    modport sink (
        input valid, output ready,
        input pressed, input released, input held, input changed,
        input press_toggle, input release_toggle,
        input press_count_out, input release_count_out,
        input multi_press, input multi_release
    );
endinterface

interface bdm_cfg_if;
    import bdm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/button_debounce_multiclick.sv -----
// button debouncer with press/release edges, toggles and multi-click counting
//
// usage: one beat on i_in per millisecond tick, carrying the raw pin level.
// every input beat produces exactly one result beat on o_out, in order.
// the tick is held in an input register, then one short pass of compare,
// increment and saturate logic updates the debounce and click state and
// loads the result register.
// throughput: one tick per cycle while o_out is not stalled; the state update
// loop (ages, levels, counts) closes in one combinational pass.
// stalls: while o_out.ready is low the result register holds; the input
// register still takes one more beat, after which i_in.ready drops until
// the result is taken.
// register writes on i_cfg are always accepted (ready tied high); indexes
// beyond the register list are dropped. write only while no tick is in flight.
// reset (synchronous, active low) clears all tick state and the valid flags of
// both pipeline slots and loads the register defaults: debounce 50, timeout 300,
// active low set, both click targets 2.
module button_debounce_multiclick (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdm_cfg_if.sink     i_cfg,
    bdm_in_if.sink      i_in,
    bdm_out_if.source   o_out
);
    import bdm_pkg::*;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? a : a + {{(AGE_W-1){1'b0}}, 1'b1};
    endfunction

    // configuration registers
    logic [15:0]      r_debounce;
    logic [15:0]      r_timeout;
    logic             r_active_low;
    logic [CNT_W-1:0] r_press_target;
    logic [CNT_W-1:0] r_release_target;

    // tick state
    logic [AGE_W-1:0] r_sample_age, n_sample_age;
    logic [AGE_W-1:0] r_press_age, n_press_age;
    logic [AGE_W-1:0] r_release_age, n_release_age;
    logic             r_level_now, n_level_now;
    logic             r_press_flip, n_press_flip;
    logic             r_release_flip, n_release_flip;
    logic [CNT_W-1:0] r_press_count, n_press_count;
    logic [CNT_W-1:0] r_release_count, n_release_count;

    // pipeline slots
    logic    r_s1_valid;
    logic    r_s1_pin;
    logic    r_out_valid;
    t_result r_out, n_out;

    logic s1_adv;
    logic in_beat;

    // combinational pass
    logic [AGE_W-1:0] samp_age_inc, p_age_inc, r_age_inc;
    logic             sample, lvl, chg, pr_edge, rl_edge;
    logic             p_in_time, r_in_time;
    logic [CNT_W-1:0] p_cnt, r_cnt;
    logic             multi_p, multi_r;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_beat    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        samp_age_inc = age_inc(r_sample_age);
        p_age_inc    = age_inc(r_press_age);
        r_age_inc    = age_inc(r_release_age);

        sample  = samp_age_inc > {1'b0, r_debounce};
        lvl     = r_s1_pin ^ r_active_low;
        chg     = sample && (lvl != r_level_now);
        pr_edge = chg && lvl;
        rl_edge = chg && !lvl;

        n_sample_age   = sample ? '0 : samp_age_inc;
        n_level_now    = sample ? lvl : r_level_now;
        n_press_flip   = r_press_flip ^ pr_edge;
        n_release_flip = r_release_flip ^ rl_edge;

        p_in_time = p_age_inc <= {1'b0, r_timeout};
        r_in_time = r_age_inc <= {1'b0, r_timeout};

        // press counting; an edge after the timeout restarts at one
        if (pr_edge) begin
            if (p_in_time) begin
                p_cnt = (r_press_count == CNT_MAX) ? CNT_MAX
                                                   : r_press_count + {{(CNT_W-1){1'b0}}, 1'b1};
            end else begin
                p_cnt = {{(CNT_W-1){1'b0}}, 1'b1};
            end
            n_press_age = '0;
        end else begin
            p_cnt       = p_in_time ? r_press_count : '0;
            n_press_age = p_age_inc;
        end

        if (rl_edge) begin
            if (r_in_time) begin
                r_cnt = (r_release_count == CNT_MAX) ? CNT_MAX
                                                     : r_release_count + {{(CNT_W-1){1'b0}}, 1'b1};
            end else begin
                r_cnt = {{(CNT_W-1){1'b0}}, 1'b1};
            end
            n_release_age = '0;
        end else begin
            r_cnt         = r_in_time ? r_release_count : '0;
            n_release_age = r_age_inc;
        end

        multi_p         = p_cnt == r_press_target;
        multi_r         = r_cnt == r_release_target;
        n_press_count   = multi_p ? '0 : p_cnt;
        n_release_count = multi_r ? '0 : r_cnt;

        n_out.pressed           = pr_edge;
        n_out.released          = rl_edge;
        n_out.held              = n_level_now;
        n_out.changed           = chg;
        n_out.press_toggle      = n_press_flip;
        n_out.release_toggle    = n_release_flip;
        n_out.press_count_out   = p_cnt;
        n_out.release_count_out = r_cnt;
        n_out.multi_press       = multi_p;
        n_out.multi_release     = multi_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce       <= DEBOUNCE_RST;
            r_timeout        <= TIMEOUT_RST;
            r_active_low     <= ACTIVE_LOW_RST;
            r_press_target   <= PRESS_TARGET_RST;
            r_release_target <= RELEASE_TARGET_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_DEBOUNCE_TICKS: r_debounce       <= i_cfg.data;
                CFG_CLICK_TIMEOUT:  r_timeout        <= i_cfg.data;
                CFG_ACTIVE_LOW:     r_active_low     <= i_cfg.data[0];
                CFG_PRESS_TARGET:   r_press_target   <= i_cfg.data[CNT_W-1:0];
                CFG_RELEASE_TARGET: r_release_target <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_age    <= '0;
            r_press_age     <= '0;
            r_release_age   <= '0;
            r_level_now     <= 1'b0;
            r_press_flip    <= 1'b0;
            r_release_flip  <= 1'b0;
            r_press_count   <= '0;
            r_release_count <= '0;
        end else if (s1_adv) begin
            r_sample_age    <= n_sample_age;
            r_press_age     <= n_press_age;
            r_release_age   <= n_release_age;
            r_level_now     <= n_level_now;
            r_press_flip    <= n_press_flip;
            r_release_flip  <= n_release_flip;
            r_press_count   <= n_press_count;
            r_release_count <= n_release_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_pin <= i_in.pin_level;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.pressed           = r_out.pressed;
    assign o_out.released          = r_out.released;
    assign o_out.held              = r_out.held;
    assign o_out.changed           = r_out.changed;
    assign o_out.press_toggle      = r_out.press_toggle;
    assign o_out.release_toggle    = r_out.release_toggle;
    assign o_out.press_count_out   = r_out.press_count_out;
    assign o_out.release_count_out = r_out.release_count_out;
    assign o_out.multi_press       = r_out.multi_press;
    assign o_out.multi_release     = r_out.multi_release;

endmodule

// ----- rtl/core/bdm_checker.sv -----
// port-level assertions for the debouncer, bound to the top level
module bdm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_pressed,
    input logic       i_released,
    input logic       i_held,
    input logic       i_changed,
    input logic [7:0] i_press_count_out
);

    // result beat must hold while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // an edge is always a change towards the new held level
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_pressed || i_released) |->
            i_changed && (i_held == i_pressed) && !(i_pressed && i_released))
        else $error("edge flags disagree with held level");

    // a change without an edge cannot happen
    a_change_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_changed |-> i_pressed || i_released)
        else $error("change reported without an edge");

    // a press is always counted
    a_press_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pressed |-> i_press_count_out != 8'd0)
        else $error("press edge left count at zero");

endmodule

bind button_debounce_multiclick bdm_checker u_bdm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_pressed         (o_out.pressed),
    .i_released        (o_out.released),
    .i_held            (o_out.held),
    .i_changed         (o_out.changed),
    .i_press_count_out (o_out.press_count_out)
);
